// ----- rtl/ps2_keyboard_controller_macros.svh -----
// Assertion macros for the PS/2 keyboard controller.
// No dependencies.
`ifndef PS2_KEYBOARD_CONTROLLER_MACROS_SVH
`define PS2_KEYBOARD_CONTROLLER_MACROS_SVH
`ifndef SYNTH
`define PS2_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PS2_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PS2_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PS2_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/ps2kbc_pkg.sv -----
// Shared constants and types for the PS/2 keyboard controller.
// No dependencies.
package ps2kbc_pkg;
   localparam int FIFO_DEPTH_DEF = 64;
   localparam int RAM_BYTES_DEF  = 32;

   localparam logic [2:0] MODE_RD_DATA = 3'd0;
   localparam logic [2:0] MODE_RD_STAT = 3'd1;
   localparam logic [2:0] MODE_WR_DATA = 3'd2;
   localparam logic [2:0] MODE_WR_CMD  = 3'd3;
   localparam logic [2:0] MODE_KBD     = 3'd4;
   localparam logic [2:0] MODE_AUX     = 3'd5;

   localparam logic CFG_FIRST  = 1'b0;
   localparam logic CFG_SECOND = 1'b1;

   localparam logic [7:0] CMD_AUX_DIS   = 8'hA7;
   localparam logic [7:0] CMD_AUX_EN    = 8'hA8;
   localparam logic [7:0] CMD_AUX_TEST  = 8'hA9;
   localparam logic [7:0] CMD_SELF_TEST = 8'hAA;
   localparam logic [7:0] CMD_KBD_TEST  = 8'hAB;
   localparam logic [7:0] CMD_DUMP      = 8'hAC;
   localparam logic [7:0] CMD_KBD_DIS   = 8'hAD;
   localparam logic [7:0] CMD_KBD_EN    = 8'hAE;
   localparam logic [7:0] CMD_RD_IN     = 8'hC0;
   localparam logic [7:0] CMD_IN_LO     = 8'hC1;
   localparam logic [7:0] CMD_IN_HI     = 8'hC2;
   localparam logic [7:0] CMD_RD_OUT    = 8'hD0;
   localparam logic [7:0] CMD_WR_OUT    = 8'hD1;
   localparam logic [7:0] CMD_PASS1     = 8'hD2;
   localparam logic [7:0] CMD_PASS2     = 8'hD3;
   localparam logic [7:0] CMD_SEND2     = 8'hD4;

   localparam logic [7:0] SELF_TEST_OK = 8'h55;
   localparam logic [7:0] NO_INPUT     = 8'hFF;
   localparam logic [7:0] IN_PORT_STAT = 8'hF0;
   localparam logic [7:0] CFG_RESET    = 8'h01;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_EXEC  = 8'b00000010,
      ST_FILLR = 8'b00000100,
      ST_FILLW = 8'b00001000,
      ST_DUMPR = 8'b00010000,
      ST_DUMPW = 8'b00100000,
      ST_CLEAR = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       read_valid;
      logic       irq_first;
      logic       irq_second;
      logic       device_write_valid;
      logic       device_write_second;
      logic [7:0] device_write_data;
      logic       cpu_reset;
      logic       cpu_halt;
   } rsp_type;
endpackage

// ----- rtl/ps2_keyboard_controller.sv -----
// PS/2 keyboard controller (8042 style), top level.
// Uses ps2kbc_pkg and ps2_keyboard_controller_macros.svh.
//
// Each request transaction is a host port access (mode 0..3) or a device
// byte (mode 4 keyboard, mode 5 aux). Every request gives one response
// transaction carrying read data, IRQ pulses, a device write, CPU reset and
// halt, and the A20 gate. One request is processed at a time.
// The response is registered after the FILLR state (memory read) and the
// EXEC state (execute). The RAM dump command adds a DUMPR/DUMPW pass, as
// it walks the RAM one byte per read/write pair, and then ST_DONE.
// No new request is accepted until the previous response has been taken,
// so a dump must finish first.
// FIFO and RAM are synchronous memories with registered read data.
// After reset a clearing pass writes every RAM byte while req_ready stays
// low; csr writes are taken at any time.
// The response sits in an output register; while rsp_ready is low it holds
// and no new request is accepted.
module ps2_keyboard_controller
   import ps2kbc_pkg::*;
#(
   parameter int FIFO_DEPTH = FIFO_DEPTH_DEF,
   parameter int RAM_BYTES  = RAM_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_read_valid,
   output logic       rsp_irq_first,
   output logic       rsp_irq_second,
   output logic       rsp_device_write_valid,
   output logic       rsp_device_write_second,
   output logic [7:0] rsp_device_write_data,
   output logic       rsp_cpu_reset,
   output logic       rsp_cpu_halt,
   output logic       rsp_a20_enable,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic       csr_write_data
);
`include "ps2_keyboard_controller_macros.svh"

   localparam int FW = $clog2(FIFO_DEPTH);
   localparam int RW = $clog2(RAM_BYTES);

   function automatic logic [FW-1:0] fifo_next(input logic [FW-1:0] p);
      return (p == FW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [FW-1:0] fifo_prev(input logic [FW-1:0] p);
      return (p == '0) ? FW'(FIFO_DEPTH - 1) : p - 1'b1;
   endfunction

   logic [7:0] fifo_mem [FIFO_DEPTH];
   logic [7:0] ram_mem  [RAM_BYTES];
   logic [7:0] fifo_q, ram_q;
   logic          fifo_we;
   logic [FW-1:0] fifo_waddr, fifo_raddr;
   logic [7:0]    fifo_wdata;
   logic          ram_we;
   logic [RW-1:0] ram_addr;
   logic [7:0]    ram_wdata;

   always_ff @(posedge clock) begin
      if (fifo_we) fifo_mem[fifo_waddr] <= fifo_wdata;
      fifo_q <= fifo_mem[fifo_raddr];
   end
   always_ff @(posedge clock) begin
      if (ram_we) ram_mem[ram_addr] <= ram_wdata;
      ram_q <= ram_mem[ram_addr];
   end

   state_type state_ff, state_in;
   logic first_ff, first_in, second_ff, second_in;
   logic [FW-1:0] rptr_ff, rptr_in, wptr_ff, wptr_in;
   logic [FW:0]   cnt_ff, cnt_in;
   logic [7:0] cfg_ff, cfg_in;
   logic [7:0] stat_ff, stat_in, host_ff, host_in, outp_ff, outp_in;
   logic [5:0] rsel_ff, rsel_in, wsel_ff, wsel_in;
   logic [5:0] pf_ff, pf_in;
   logic [8:0] dev0_ff, dev0_in, dev1_ff, dev1_in;
   logic [2:0] mode_ff, mode_in;
   logic [7:0] val_ff, val_in;
   logic [RW:0] idx_ff, idx_in;
   rsp_type rsp_ff, rsp_in;
   logic rspv_ff, rspv_in;

   assign req_ready = (state_ff == ST_IDLE) && !rspv_ff;
   assign rsp_valid = rspv_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_read_valid = rsp_ff.read_valid;
   assign rsp_irq_first = rsp_ff.irq_first;
   assign rsp_irq_second = rsp_ff.irq_second;
   assign rsp_device_write_valid = rsp_ff.device_write_valid;
   assign rsp_device_write_second = rsp_ff.device_write_second;
   assign rsp_device_write_data = rsp_ff.device_write_data;
   assign rsp_cpu_reset = rsp_ff.cpu_reset;
   assign rsp_cpu_halt = rsp_ff.cpu_halt;
   assign rsp_a20_enable = outp_ff[1];

   // fill needs FIFO data: fifo_q holds fifo_mem[rptr_ff], read every cycle
   logic need_fill;
   always_comb begin
      need_fill = 1'b0;
      if (mode_ff == MODE_RD_DATA)
         need_fill = !pf_ff[0] && rsel_ff == '0;
      else if (mode_ff == MODE_RD_STAT)
         need_fill = 1'b1;
      else if (mode_ff == MODE_WR_CMD)
         need_fill = val_ff == CMD_RD_IN || val_ff == CMD_IN_LO || val_ff == CMD_IN_HI;
   end

   logic [7:0] s, h, b;
   logic [5:0] pf;
   logic [FW:0] c;
   logic [FW-1:0] wp, rp;
   logic pv, sent;

   always_comb begin
      state_in = state_ff;
      first_in = first_ff; second_in = second_ff;
      if (csr_write_enable) begin
         if (csr_index == CFG_FIRST) first_in = csr_write_data;
         else second_in = csr_write_data;
      end
      rptr_in = rptr_ff; wptr_in = wptr_ff; cnt_in = cnt_ff;
      cfg_in = cfg_ff; stat_in = stat_ff; host_in = host_ff; outp_in = outp_ff;
      rsel_in = rsel_ff; wsel_in = wsel_ff; pf_in = pf_ff;
      dev0_in = dev0_ff; dev1_in = dev1_ff;
      mode_in = mode_ff; val_in = val_ff; idx_in = idx_ff;
      rsp_in = rsp_ff; rspv_in = rspv_ff;
      fifo_we = 1'b0; fifo_waddr = wptr_ff; fifo_wdata = 8'h00;
      fifo_raddr = rptr_ff;
      ram_we = 1'b0; ram_addr = '0; ram_wdata = 8'h00;
      s = stat_ff; h = host_ff; pf = pf_ff; c = cnt_ff; wp = wptr_ff; rp = rptr_ff;
      b = 8'h00; pv = 1'b0; sent = 1'b0;
      if (rspv_ff && rsp_ready) rspv_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_addr = idx_ff[RW-1:0];
            ram_wdata = (idx_ff == '0) ? CFG_RESET : 8'h00;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (RW+1)'(RAM_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               mode_in = req_mode; val_in = req_value;
               // read-select RAM byte
               ram_addr = rsel_ff[RW-1:0] - 1'b1;
               state_in = ST_FILLR;
            end
         end
         ST_FILLR: begin
            // FIFO read data for rptr_ff now registered; RAM byte too
            ram_addr = rsel_ff[RW-1:0] - 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            rsp_in = '0;
            // fill step
            if (need_fill && !s[1]) begin
               h = 8'h00;
               if (c != '0) begin
                  h = fifo_q; rp = fifo_next(rptr_ff); c = c - 1'b1;
                  s = (s & ~8'h20) | 8'h02;
               end else if (first_ff && dev0_ff[8]) begin
                  h = dev0_ff[7:0]; dev0_in = '0; s = (s & ~8'h20) | 8'h02;
               end else if (second_ff && dev1_ff[8]) begin
                  h = dev1_ff[7:0]; dev1_in = '0; s = s | 8'h22;
               end
            end
            case (mode_ff)
               MODE_RD_DATA: begin
                  rsp_in.read_valid = 1'b1;
                  if (pf[0]) begin
                     rsp_in.read_data = outp_ff; pf[0] = 1'b0;
                  end else if (rsel_ff != '0) begin
                     rsp_in.read_data = ram_q; rsel_in = '0;
                  end else if (s[1]) begin
                     rsp_in.read_data = h; s = s & ~8'h22;
                  end else rsp_in.read_valid = 1'b0;
               end
               MODE_RD_STAT: begin
                  rsp_in.read_data = s; rsp_in.read_valid = 1'b1;
               end
               MODE_WR_DATA: begin
                  if (pf[1]) begin
                     outp_in = val_ff; pf[1] = 1'b0; s = s & ~8'h01;
                  end else if (wsel_ff != '0) begin
                     ram_we = 1'b1; ram_addr = wsel_ff[RW-1:0] - 1'b1; ram_wdata = val_ff;
                     if (wsel_ff == 6'd1) cfg_in = val_ff;
                     wsel_in = '0; s = s & ~8'h01;
                  end else begin
                     s = s & ~8'h08;
                     if (pf[2] || pf[3]) begin
                        h = val_ff; s = s | 8'h02;
                        if (pf[3]) begin
                           s = s | 8'h20; rsp_in.irq_second = cfg_ff[1];
                        end else begin
                           s = s & ~8'h20; rsp_in.irq_first = cfg_ff[0];
                        end
                        pf[3:2] = 2'b00;
                     end else begin
                        if (!pf[4] && !pf[5]) pf[4] = 1'b1;
                        if (pf[4] && first_ff) begin
                           sent = 1'b1; pf[4] = 1'b0;
                           rsp_in.device_write_second = 1'b0;
                        end else if (pf[5] && second_ff) begin
                           sent = 1'b1; pf[5] = 1'b0;
                           rsp_in.device_write_second = 1'b1;
                        end
                        if (sent) begin
                           s = s & ~8'h01;
                           rsp_in.device_write_valid = 1'b1;
                           rsp_in.device_write_data = val_ff;
                        end
                     end
                  end
               end
               MODE_WR_CMD: begin
                  s = s & ~8'h01;
                  if (val_ff[7:4] == 4'h6) begin
                     wsel_in = 6'(val_ff - 8'h5F); pf[1] = 1'b0;
                  end else if (val_ff[7:4] == 4'h2) begin
                     rsel_in = 6'(val_ff - 8'h1F); pf[0] = 1'b0;
                  end else if (val_ff[7:4] == 4'hF) begin
                     if (!val_ff[0]) begin
                        rsp_in.cpu_halt = !outp_ff[0]; rsp_in.cpu_reset = 1'b1;
                     end
                  end else begin
                     case (val_ff)
                        CMD_AUX_DIS: cfg_in = cfg_ff | 8'h20;
                        CMD_AUX_EN:  cfg_in = cfg_ff & ~8'h20;
                        CMD_KBD_DIS: cfg_in = cfg_ff | 8'h10;
                        CMD_KBD_EN:  cfg_in = cfg_ff & ~8'h10;
                        CMD_AUX_TEST: begin pv = 1'b1; b = {7'd0, !second_ff}; end
                        CMD_KBD_TEST: begin pv = 1'b1; b = {7'd0, !first_ff}; end
                        CMD_SELF_TEST: begin pv = 1'b1; b = SELF_TEST_OK; end
                        CMD_DUMP: begin pv = 1'b1; b = cfg_ff; end
                        CMD_RD_IN: begin pv = 1'b1; b = s[1] ? h : NO_INPUT; end
                        CMD_IN_LO, CMD_IN_HI: s = IN_PORT_STAT;
                        CMD_RD_OUT: begin pf[0] = 1'b1; rsel_in = '0; end
                        CMD_WR_OUT: begin pf[1] = 1'b1; wsel_in = '0; end
                        CMD_PASS1: pf[2] = 1'b1;
                        CMD_PASS2: pf[3] = 1'b1;
                        CMD_SEND2: pf[5] = 1'b1;
                        default: ;
                     endcase
                     // config byte lives in RAM byte 0 as well
                     if (cfg_in != cfg_ff) begin
                        ram_we = 1'b1; ram_addr = '0; ram_wdata = cfg_in;
                     end
                     if (pv && c < (FW+1)'(FIFO_DEPTH)) begin
                        fifo_we = 1'b1; fifo_waddr = wp; fifo_wdata = b;
                        wp = fifo_next(wp); c = c + 1'b1;
                     end
                     if (pv && val_ff != CMD_RD_IN && c != '0) begin
                        rp = fifo_prev(wp); c = (FW+1)'(1);
                     end
                  end
               end
               MODE_KBD: dev0_in = {1'b1, val_ff};
               MODE_AUX: dev1_in = {1'b1, val_ff};
               default: ;
            endcase
            stat_in = s; host_in = h; pf_in = pf;
            rptr_in = rp; wptr_in = wp; cnt_in = c;
            if (mode_ff == MODE_WR_CMD && val_ff == CMD_DUMP) begin
               idx_in = (RW+1)'(1); state_in = ST_DUMPR;
            end else begin
               rspv_in = 1'b1; state_in = ST_IDLE;
            end
         end
         ST_DUMPR: begin
            ram_addr = idx_ff[RW-1:0];
            state_in = ST_DUMPW;
         end
         ST_DUMPW: begin
            if (cnt_ff < (FW+1)'(FIFO_DEPTH)) begin
               fifo_we = 1'b1; fifo_wdata = ram_q;
               wptr_in = fifo_next(wptr_ff); cnt_in = cnt_ff + 1'b1;
            end
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff == (RW+1)'(RAM_BYTES - 1)) ? ST_DONE : ST_DUMPR;
         end
         ST_DONE: begin
            rspv_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         first_ff <= 1'b1; second_ff <= 1'b0;
         rptr_ff <= '0; wptr_ff <= '0; cnt_ff <= '0;
         cfg_ff <= CFG_RESET; stat_ff <= '0; host_ff <= '0; outp_ff <= '0;
         rsel_ff <= '0; wsel_ff <= '0; pf_ff <= '0;
         dev0_ff <= '0; dev1_ff <= '0;
         idx_ff <= '0; rspv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in; second_ff <= second_in;
         rptr_ff <= rptr_in; wptr_ff <= wptr_in; cnt_ff <= cnt_in;
         cfg_ff <= cfg_in; stat_ff <= stat_in; host_ff <= host_in; outp_ff <= outp_in;
         rsel_ff <= rsel_in; wsel_ff <= wsel_in; pf_ff <= pf_in;
         dev0_ff <= dev0_in; dev1_ff <= dev1_in;
         idx_ff <= idx_in; rspv_ff <= rspv_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in; val_ff <= val_in; rsp_ff <= rsp_in;
   end

   `PS2_ASSERT_IMPL(a_cnt_range, clock, reset, 1'b1, cnt_ff <= (FW+1)'(FIFO_DEPTH))
   `PS2_ASSERT_IMPL(a_no_req_busy, clock, reset, state_ff != ST_IDLE, !req_ready)
   `PS2_ASSERT_NEXT(a_rsp_hold, clock, reset, rspv_ff && !rsp_ready, rspv_ff)
   `PS2_ASSERT_IMPL(a_halt_reset, clock, reset, rspv_ff && rsp_ff.cpu_halt, rsp_ff.cpu_reset)
endmodule
